// ===== rtl/minimal_standard_random_ranged_core_macros.svh =====
// Assertion macros shared by the checker of the ranged random generator.
`ifndef MINIMAL_STANDARD_RANDOM_RANGED_CORE_MACROS_SVH
`define MINIMAL_STANDARD_RANDOM_RANGED_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MSRR_ASSERT_IMPLY(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define MSRR_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed");

`endif

// ===== rtl/msrr_pkg.sv =====
// Package with types and constants of the ranged random generator.
`default_nettype none

package msrr_pkg;

    localparam int unsigned StateW  = 31;
    localparam int unsigned DataW   = 32;
    localparam int unsigned MultW   = 15;
    localparam int unsigned ProdW   = StateW + MultW;
    localparam int unsigned DivSteps = StateW;
    localparam int unsigned CntW    = $clog2(DivSteps);

    localparam logic [MultW-1:0]  MsrMult = 15'd16807;
    localparam logic [StateW-1:0] MsrMod  = 31'h7FFF_FFFF;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_FOLD,
        ST_DIV,
        ST_DONE
    } msrr_state_t;

    typedef struct packed {
        logic start;
        logic mul;
        logic fold;
        logic div_step;
        logic finish;
    } msrr_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/msrr_if.sv =====
// Handshake interfaces for draw requests, results and seed writes.
`default_nettype none

interface msrr_draw_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] range_low;
    logic signed [31:0] range_high;

    modport source (output valid, output range_low, output range_high, input ready);
    modport sink   (input valid, input range_low, input range_high, output ready);
endinterface

interface msrr_result_if;
    logic               valid;
    logic               ready;
    logic [30:0]        raw_value;
    logic signed [31:0] ranged_value;
    logic               span_zero;

    modport source (output valid, output raw_value, output ranged_value, output span_zero,
                    input ready);
    modport sink   (input valid, input raw_value, input ranged_value, input span_zero,
                    output ready);
endinterface

interface msrr_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] seed_value;

    modport source (output valid, output seed_value, input ready);
    modport sink   (input valid, input seed_value, output ready);
endinterface

`default_nettype wire

// ===== rtl/minimal_standard_random_ranged_core.sv =====
// Top level of the minimal standard random generator with ranged draws.
// Each draw item passes from acceptance to a valid result through a multiply of the
// state by 16807, a fold of the product modulo 2^31-1, the bit-serial restoring
// remainder unit that reduces the 31-bit raw value by the 32-bit span, and a load of
// the result register. One draw is in flight at a time; the next is accepted while
// the previous result waits to be taken. A seed write is taken in any cycle and
// reloads the state with seed+1 reduced modulo 2^31-1 (one for a zero residue);
// write it only while no draw is in flight.
`default_nettype none

module minimal_standard_random_ranged_core
    import msrr_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    msrr_draw_if.sink    draw,
    msrr_result_if.source result,
    msrr_cfg_if.sink     cfg
);

    msrr_cmd_t cmd;

    // Seed writes are always taken
    assign cfg.ready = 1'b1;

    msrr_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (draw.valid),
        .in_ready  (draw.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .cmd       (cmd)
    );

    msrr_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .range_low    (draw.range_low),
        .range_high   (draw.range_high),
        .seed_we      (cfg.valid),
        .seed_value   (cfg.seed_value),
        .raw_value    (result.raw_value),
        .ranged_value (result.ranged_value),
        .span_zero    (result.span_zero)
    );

endmodule

`default_nettype wire

// ===== rtl/msrr_datapath.sv =====
// Datapath: generator state, multiply and fold, restoring remainder unit, result registers.
`default_nettype none

module msrr_datapath
    import msrr_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire msrr_cmd_t          cmd,
    input  wire logic signed [31:0] range_low,
    input  wire logic signed [31:0] range_high,
    input  wire logic               seed_we,
    input  wire logic [DataW-1:0]   seed_value,
    output logic [StateW-1:0]       raw_value,
    output logic signed [31:0]      ranged_value,
    output logic                    span_zero
);

    logic [StateW-1:0] state_reg, state_next;
    logic [DataW-1:0]  low_reg;
    logic [DataW-1:0]  span_reg;
    logic [ProdW-1:0]  prod_reg;
    logic [StateW-1:0] dvd_reg;
    logic [DataW-1:0]  rem_reg;
    logic [StateW-1:0] raw_reg;
    logic [DataW-1:0]  ranged_reg;
    logic              zero_reg;

    logic [ProdW-1:0]  prod_next;
    logic [DataW-1:0]  fold1;
    logic [StateW-1:0] fold2;
    logic [DataW-1:0]  seed_inc;
    logic [StateW-1:0] seed_red;
    logic [StateW-1:0] seed_load;
    logic [DataW:0]    rem_shift;
    logic [DataW:0]    rem_diff;
    logic [DataW-1:0]  rem_next;
    logic              span_is_zero;

    // Multiply the state by the generator constant
    assign prod_next = ProdW'(state_reg) * ProdW'(MsrMult);

    // Fold the product twice using 2^31 == 1 modulo 2^31-1
    assign fold1 = DataW'(prod_reg[StateW-1:0]) + DataW'(prod_reg[ProdW-1:StateW]);
    assign fold2 = fold1[StateW-1:0] + StateW'(fold1[DataW-1]);

    // Reduce seed plus one modulo 2^31-1, replace a zero residue with one
    always_comb
    begin
        seed_inc = seed_value + 32'd1;
        seed_red = seed_inc[StateW-1:0] + StateW'(seed_inc[DataW-1]);
        if (seed_red == MsrMod)
        begin
            seed_red = '0;
        end
        seed_load = (seed_red == '0) ? StateW'(1) : seed_red;
    end

    // One restoring remainder step: shift in the next dividend bit, subtract if it fits
    always_comb
    begin
        rem_shift = {rem_reg, dvd_reg[StateW-1]};
        rem_diff  = rem_shift - {1'b0, span_reg};
        rem_next  = rem_diff[DataW] ? rem_shift[DataW-1:0] : rem_diff[DataW-1:0];
    end

    assign span_is_zero = (span_reg == '0);

    // Generator state: reload on seed write, advance on fold
    always_comb
    begin
        state_next = state_reg;
        if (seed_we)
        begin
            state_next = seed_load;
        end
        else if (cmd.fold)
        begin
            state_next = fold2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= StateW'(1);
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Operand, product, divider and result registers
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            low_reg  <= DataW'(range_low);
            span_reg <= DataW'(range_high) - DataW'(range_low);
        end
        if (cmd.mul)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.fold)
        begin
            dvd_reg <= fold2;
            rem_reg <= '0;
        end
        if (cmd.div_step)
        begin
            dvd_reg <= {dvd_reg[StateW-2:0], 1'b0};
            rem_reg <= rem_next;
        end
        if (cmd.finish)
        begin
            raw_reg    <= state_reg;
            zero_reg   <= span_is_zero;
            ranged_reg <= span_is_zero ? low_reg : rem_reg + low_reg;
        end
    end

    assign raw_value    = raw_reg;
    assign ranged_value = ranged_reg;
    assign span_zero    = zero_reg;

endmodule

`default_nettype wire

// ===== rtl/msrr_controller.sv =====
// Controller: sequences one draw through multiply, fold, remainder steps and result hand-off.
`default_nettype none

module msrr_controller
    import msrr_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  wire logic out_ready,
    output msrr_cmd_t cmd
);

    msrr_state_t     state_reg, state_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic            out_valid_reg, out_valid_next;

    // State, step counter and result valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        cmd            = '0;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_FOLD;
            end
            ST_FOLD:
            begin
                cmd.fold   = 1'b1;
                cnt_next   = CntW'(DivSteps - 1);
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg - CntW'(1);
                end
            end
            ST_DONE:
            begin
                // Hold the finished item until the result register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ===== rtl/msrr_checker.sv =====
// Port-level checker for the ranged random generator, bound to the top level.
`default_nettype none
`include "minimal_standard_random_ranged_core_macros.svh"

module msrr_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        draw_valid,
    input wire logic        draw_ready,
    input wire logic        res_valid,
    input wire logic        res_ready,
    input wire logic [30:0] raw_value,
    input wire logic [31:0] ranged_value,
    input wire logic        span_zero
);

    logic [63:0] res_payload;

    // Gather the result fields into one word
    assign res_payload = {raw_value, ranged_value, span_zero};

    // A stalled result stays offered
    `MSRR_ASSERT_NEXT(a_res_hold, clk, rst_n, res_valid && !res_ready, res_valid)

    // A stalled result keeps its payload
    `MSRR_ASSERT_NEXT(a_res_stable, clk, rst_n, res_valid && !res_ready, $stable(res_payload))

    // The raw value never leaves the generator's legal range
    `MSRR_ASSERT_IMPLY(a_raw_range, clk, rst_n, res_valid, raw_value != 31'd0 && raw_value != 31'h7FFF_FFFF)

    // One draw at a time: no new draw right after one is taken
    `MSRR_ASSERT_NEXT(a_one_draw, clk, rst_n, draw_valid && draw_ready, !draw_ready)

    // A result never appears the cycle after a draw is taken
    `MSRR_ASSERT_NEXT(a_no_early, clk, rst_n, draw_valid && draw_ready, !$rose(res_valid))

endmodule

bind minimal_standard_random_ranged_core msrr_checker u_msrr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .draw_valid   (draw.valid),
    .draw_ready   (draw.ready),
    .res_valid    (result.valid),
    .res_ready    (result.ready),
    .raw_value    (result.raw_value),
    .ranged_value (result.ranged_value),
    .span_zero    (result.span_zero)
);

`default_nettype wire
